>>> rtl/core/rgbw_pkg.sv
// Shared types, register codes and helpers for the RGB to RGBW pixel converter.
`timescale 1ns / 1ps

package rgbw_pkg;

    // Register indexes on the configuration channel
    localparam logic [7:0] REG_BRIGHTNESS    = 8'd0;
    localparam logic [7:0] REG_WHITE_RED     = 8'd1;
    localparam logic [7:0] REG_WHITE_GREEN   = 8'd2;
    localparam logic [7:0] REG_WHITE_BLUE    = 8'd3;

    localparam logic [7:0] CHAN_MAX          = 8'd255;

    // Divider geometry: 8 quotient bits, two restoring steps per stage
    localparam int QUO_BITS   = 8;
    localparam int STEP_BITS  = 2;
    localparam int DIV_STAGES = QUO_BITS / STEP_BITS;

    // Divider lanes: white level and the three colour reductions
    localparam int NUM_LANES  = 4;
    localparam int LANE_W     = 0;
    localparam int LANE_R     = 1;
    localparam int LANE_G     = 2;
    localparam int LANE_B     = 3;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] white_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } drive_t;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] value;
    } cfg_t;

    // White LED content; a zero content acts as one
    function automatic logic [7:0] content_of(input logic [7:0] k);
        return (k == 8'd0) ? 8'd1 : k;
    endfunction

endpackage

>>> rtl/core/rgbw_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface rgbw_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/rgbw_div_step.sv
// Restoring division step: retires STEP_BITS quotient bits against an 8-bit divisor.
`timescale 1ns / 1ps

module rgbw_div_step (
    input  logic [7:0]                    rem_in,
    input  logic [rgbw_pkg::STEP_BITS-1:0] num_bits,
    input  logic [7:0]                    divisor,
    output logic [7:0]                    rem_out,
    output logic [rgbw_pkg::STEP_BITS-1:0] q_bits
);

    logic [7:0] rem;
    logic [8:0] trial;
    logic [7:0] diff;

    // Shift in one dividend bit, subtract when it fits, repeat
    always_comb
    begin
        rem    = rem_in;
        trial  = 9'd0;
        diff   = 8'd0;
        q_bits = '0;
        for (int i = rgbw_pkg::STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {rem, num_bits[i]};
            diff  = trial[7:0] - divisor;
            if (trial >= {1'b0, divisor})
            begin
                rem       = diff;
                q_bits[i] = 1'b1;
            end
            else
            begin
                rem       = trial[7:0];
                q_bits[i] = 1'b0;
            end
        end
        rem_out = rem;
    end

endmodule

>>> rtl/core/rgb_to_rgbw_pixel_converter.sv
// Top level of the RGB to RGBW pixel converter: pipeline, config registers, checks.
//
// Usage:
//   pixel : sink channel, one RGB pixel (red_in, green_in, blue_in) per transaction.
//   drive : source channel, one RGBW result (white_out, red_out, green_out,
//           blue_out) per accepted pixel, in order.
//   cfg   : write channel (index, value); index 0 brightness, 1..3 the white LED's
//           red, green, blue content. Other indexes are dropped. Always ready.
//           Write only while no pixel is in flight.
// Throughput: one pixel per clock while drive takes results. A pixel reaches drive
//   through nine register stages: scale multiply, cross products, minimum select,
//   numerator multiply, four divider stages (two quotient bits each, set by the 8-bit
//   restoring divider), output subtract and clamp.
// Reset: clears every stage valid bit and loads all four registers with 255.
// Stall: when drive is not taken, the output holds and bubbles inside the
//   pipeline still fill; pixel.ready drops only when every stage is occupied.
`timescale 1ns / 1ps

module rgb_to_rgbw_pixel_converter (
    input  logic              clk,
    input  logic              rst_n,
    rgbw_stream_if.sink       pixel,
    rgbw_stream_if.source     drive,
    rgbw_stream_if.sink       cfg
);

    localparam int NL = rgbw_pkg::NUM_LANES;
    localparam int DS = rgbw_pkg::DIV_STAGES;
    localparam int SB = rgbw_pkg::STEP_BITS;
    localparam int QB = rgbw_pkg::QUO_BITS;
    localparam int DIV_FIRST = 4;
    localparam int NS = DIV_FIRST + DS + 1;

    typedef struct packed {
        logic [7:0] r, g, b, kr, kg, kb;
    } s1_t;

    typedef struct packed {
        logic [7:0]  r, g, b, kr, kg, kb;
        logic [15:0] g_kr, r_kg, b_kr, r_kb, b_kg, g_kb;
    } s2_t;

    typedef struct packed {
        logic [7:0] r, g, b, kr, kg, kb, v, k;
    } s3_t;

    typedef struct packed {
        logic [NL-1:0][7:0] rem;
        logic [NL-1:0][7:0] low;
        logic [NL-1:0][7:0] quo;
        logic               sat;
        logic [7:0]         r, g, b, k;
    } dv_t;

    // Configuration registers
    logic [7:0] brightness_reg;
    logic [7:0] white_red_content_reg;
    logic [7:0] white_green_content_reg;
    logic [7:0] white_blue_content_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg          <= rgbw_pkg::CHAN_MAX;
            white_red_content_reg   <= rgbw_pkg::CHAN_MAX;
            white_green_content_reg <= rgbw_pkg::CHAN_MAX;
            white_blue_content_reg  <= rgbw_pkg::CHAN_MAX;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                rgbw_pkg::REG_BRIGHTNESS:  brightness_reg          <= cfg.data.value;
                rgbw_pkg::REG_WHITE_RED:   white_red_content_reg   <= cfg.data.value;
                rgbw_pkg::REG_WHITE_GREEN: white_green_content_reg <= cfg.data.value;
                rgbw_pkg::REG_WHITE_BLUE:  white_blue_content_reg  <= cfg.data.value;
                default: ;
            endcase
        end
    end

    // Stage control: a stage advances when empty or when the next one advances
    logic [NS:1]   valid_reg;
    logic [NS:1]   valid_next;
    logic [NS+1:1] adv;

    always_comb
    begin
        adv[NS+1] = drive.ready;
        for (int i = NS; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = {valid_reg[NS-1:1], pixel.valid};
    end

    assign pixel.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= NS; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // Stage 1: scale by brightness, capture the white content with the pixel
    s1_t         s1_next, s1_reg;
    logic [15:0] pr, pg, pb;

    always_comb
    begin
        pr         = 16'(pixel.data.red_in)   * 16'(brightness_reg);
        pg         = 16'(pixel.data.green_in) * 16'(brightness_reg);
        pb         = 16'(pixel.data.blue_in)  * 16'(brightness_reg);
        s1_next.r  = pr[15:8];
        s1_next.g  = pg[15:8];
        s1_next.b  = pb[15:8];
        s1_next.kr = rgbw_pkg::content_of(white_red_content_reg);
        s1_next.kg = rgbw_pkg::content_of(white_green_content_reg);
        s1_next.kb = rgbw_pkg::content_of(white_blue_content_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: every cross product the minimum search can need
    s2_t s2_next, s2_reg;

    always_comb
    begin
        s2_next.r    = s1_reg.r;
        s2_next.g    = s1_reg.g;
        s2_next.b    = s1_reg.b;
        s2_next.kr   = s1_reg.kr;
        s2_next.kg   = s1_reg.kg;
        s2_next.kb   = s1_reg.kb;
        s2_next.g_kr = 16'(s1_reg.g) * 16'(s1_reg.kr);
        s2_next.r_kg = 16'(s1_reg.r) * 16'(s1_reg.kg);
        s2_next.b_kr = 16'(s1_reg.b) * 16'(s1_reg.kr);
        s2_next.r_kb = 16'(s1_reg.r) * 16'(s1_reg.kb);
        s2_next.b_kg = 16'(s1_reg.b) * 16'(s1_reg.kg);
        s2_next.g_kb = 16'(s1_reg.g) * 16'(s1_reg.kb);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: pick the channel needing the least white; ties keep the earlier one
    s3_t         s3_next, s3_reg;
    logic        sel_g, sel_b;
    logic [15:0] b_k, v_kb;

    always_comb
    begin
        sel_g      = s2_reg.g_kr < s2_reg.r_kg;
        b_k        = sel_g ? s2_reg.b_kg : s2_reg.b_kr;
        v_kb       = sel_g ? s2_reg.g_kb : s2_reg.r_kb;
        sel_b      = b_k < v_kb;
        s3_next.r  = s2_reg.r;
        s3_next.g  = s2_reg.g;
        s3_next.b  = s2_reg.b;
        s3_next.kr = s2_reg.kr;
        s3_next.kg = s2_reg.kg;
        s3_next.kb = s2_reg.kb;
        if (sel_b)
        begin
            s3_next.v = s2_reg.b;
            s3_next.k = s2_reg.kb;
        end
        else if (sel_g)
        begin
            s3_next.v = s2_reg.g;
            s3_next.k = s2_reg.kg;
        end
        else
        begin
            s3_next.v = s2_reg.r;
            s3_next.k = s2_reg.kr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_reg <= s3_next;
        end
    end

    // Stage 4: dividends; colour lanes get k-1 added so the floor becomes a ceiling
    dv_t         dv_first;
    logic [15:0] nw;
    logic [15:0] nr, ng, nb;

    always_comb
    begin
        nw = 16'(s3_reg.v) * 16'(rgbw_pkg::CHAN_MAX);
        nr = 16'(s3_reg.v) * 16'(s3_reg.kr) + 16'(s3_reg.k) - 16'd1;
        ng = 16'(s3_reg.v) * 16'(s3_reg.kg) + 16'(s3_reg.k) - 16'd1;
        nb = 16'(s3_reg.v) * 16'(s3_reg.kb) + 16'(s3_reg.k) - 16'd1;
        dv_first.sat                  = nw[15:8] >= s3_reg.k;
        dv_first.rem[rgbw_pkg::LANE_W] = nw[15:8];
        dv_first.low[rgbw_pkg::LANE_W] = nw[7:0];
        dv_first.rem[rgbw_pkg::LANE_R] = nr[15:8];
        dv_first.low[rgbw_pkg::LANE_R] = nr[7:0];
        dv_first.rem[rgbw_pkg::LANE_G] = ng[15:8];
        dv_first.low[rgbw_pkg::LANE_G] = ng[7:0];
        dv_first.rem[rgbw_pkg::LANE_B] = nb[15:8];
        dv_first.low[rgbw_pkg::LANE_B] = nb[7:0];
        dv_first.quo = '0;
        dv_first.r   = s3_reg.r;
        dv_first.g   = s3_reg.g;
        dv_first.b   = s3_reg.b;
        dv_first.k   = s3_reg.k;
    end

    // Stages 5 to 8: pipelined restoring divider, four lanes side by side
    dv_t          dv_reg  [0:DS];
    dv_t          dv_next [1:DS];
    logic [7:0]   rem_o   [DS][NL];
    logic [SB-1:0] qb     [DS][NL];

    for (genvar s = 0; s < DS; s++)
    begin : g_div_stage
        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            rgbw_div_step u_step (
                .rem_in   (dv_reg[s].rem[l]),
                .num_bits (dv_reg[s].low[l][7 -: SB]),
                .divisor  (dv_reg[s].k),
                .rem_out  (rem_o[s][l]),
                .q_bits   (qb[s][l])
            );
        end
    end

    always_comb
    begin
        for (int s = 0; s < DS; s++)
        begin
            dv_next[s+1] = dv_reg[s];
            for (int l = 0; l < NL; l++)
            begin
                dv_next[s+1].rem[l] = rem_o[s][l];
                dv_next[s+1].low[l] = dv_reg[s].low[l] << SB;
                dv_next[s+1].quo[l] = {dv_reg[s].quo[l][QB-SB-1:0], qb[s][l]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[DIV_FIRST])
        begin
            dv_reg[0] <= dv_first;
        end
        for (int s = 1; s <= DS; s++)
        begin
            if (adv[DIV_FIRST+s])
            begin
                dv_reg[s] <= dv_next[s];
            end
        end
    end

    // Stage 9: saturate white, remove the white share from each colour
    rgbw_pkg::drive_t out_next, out_reg;
    dv_t              dv_last;

    always_comb
    begin
        dv_last            = dv_reg[DS];
        out_next.white_out = dv_last.sat ? rgbw_pkg::CHAN_MAX
                                         : dv_last.quo[rgbw_pkg::LANE_W];
        out_next.red_out   = (dv_last.r > dv_last.quo[rgbw_pkg::LANE_R])
                           ? dv_last.r - dv_last.quo[rgbw_pkg::LANE_R] : 8'd0;
        out_next.green_out = (dv_last.g > dv_last.quo[rgbw_pkg::LANE_G])
                           ? dv_last.g - dv_last.quo[rgbw_pkg::LANE_G] : 8'd0;
        out_next.blue_out  = (dv_last.b > dv_last.quo[rgbw_pkg::LANE_B])
                           ? dv_last.b - dv_last.quo[rgbw_pkg::LANE_B] : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS])
        begin
            out_reg <= out_next;
        end
    end

    assign drive.valid = valid_reg[NS];
    assign drive.data  = out_reg;

    // Checks

    // An empty output stage leaves every upstream stage free to move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NS] |-> pixel.ready)
        else $error("pixel.ready low while the output stage is empty");

    // The chosen minimum keeps every quotient within eight bits
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DIV_FIRST] |->
            (dv_reg[0].sat || (dv_reg[0].rem[rgbw_pkg::LANE_W] < dv_reg[0].k)) &&
            (dv_reg[0].rem[rgbw_pkg::LANE_R] < dv_reg[0].k) &&
            (dv_reg[0].rem[rgbw_pkg::LANE_G] < dv_reg[0].k) &&
            (dv_reg[0].rem[rgbw_pkg::LANE_B] < dv_reg[0].k))
        else $error("divider dividend out of range");

    // The channel that sets the white level is fully absorbed into white
    a_one_colour_zero: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |->
            (drive.data.red_out == 8'd0) || (drive.data.green_out == 8'd0) ||
            (drive.data.blue_out == 8'd0))
        else $error("no colour channel fully replaced by white");

endmodule

>>> tb/rgbw_checker.sv
// Checker for the RGB to RGBW converter: tracks registers, predicts drives, compares results.
`timescale 1ns / 1ps

module rgbw_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    input  logic              pixel_ready,
    input  rgbw_pkg::pixel_t  pixel_data,
    input  logic              drive_valid,
    input  logic              drive_ready,
    input  rgbw_pkg::drive_t  drive_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  rgbw_pkg::cfg_t    cfg_data,
    output int unsigned       mismatches,
    output int unsigned       pending
);

    // Shadow copy of the configuration registers
    logic [7:0] gain;
    logic [7:0] white_r;
    logic [7:0] white_g;
    logic [7:0] white_b;

    // Predicted drive values, oldest first
    rgbw_pkg::drive_t predicted_drives[$];

    // Remove the white share from one colour: c - ceil(v*kc/k), floored at zero
    function automatic logic [7:0] strip_white(input logic [7:0] c, input logic [7:0] kc,
                                               input logic [7:0] v, input logic [7:0] k);
        logic [15:0] share;
        logic [15:0] taken;
        share = v * kc;
        taken = (share + k - 16'd1) / k;
        return (c > taken) ? c - taken[7:0] : 8'd0;
    endfunction

    // Expected RGBW drive for one pixel under the current registers
    function automatic rgbw_pkg::drive_t rgbw_of(input rgbw_pkg::pixel_t p);
        logic [7:0]       kr, kg, kb, k, v, sr, sg, sb;
        logic [15:0]      prod_r, prod_g, prod_b, lhs, rhs, level;
        rgbw_pkg::drive_t d;
        kr = (white_r == 8'd0) ? 8'd1 : white_r;
        kg = (white_g == 8'd0) ? 8'd1 : white_g;
        kb = (white_b == 8'd0) ? 8'd1 : white_b;
        prod_r = p.red_in * gain;
        prod_g = p.green_in * gain;
        prod_b = p.blue_in * gain;
        sr = prod_r[15:8];
        sg = prod_g[15:8];
        sb = prod_b[15:8];
        // Pick the channel needing the least white; earlier channel wins ties
        v = sr;
        k = kr;
        lhs = sg * k;
        rhs = v * kg;
        if (lhs < rhs)
        begin
            v = sg;
            k = kg;
        end
        lhs = sb * k;
        rhs = v * kb;
        if (lhs < rhs)
        begin
            v = sb;
            k = kb;
        end
        level = (v * 16'd255) / k;
        d.white_out = (level > 16'd255) ? 8'd255 : level[7:0];
        d.red_out   = strip_white(sr, kr, v, k);
        d.green_out = strip_white(sg, kg, v, k);
        d.blue_out  = strip_white(sb, kb, v, k);
        return d;
    endfunction

    // Report one field; returns 1 on a mismatch
    function automatic int unsigned field_bad(input string name, input logic [7:0] want,
                                              input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Follow register writes, queue predictions, check each drive transaction
    always @(posedge clk or negedge rst_n)
    begin
        rgbw_pkg::drive_t want;
        if (!rst_n)
        begin
            gain = rgbw_pkg::CHAN_MAX;
            white_r = rgbw_pkg::CHAN_MAX;
            white_g = rgbw_pkg::CHAN_MAX;
            white_b = rgbw_pkg::CHAN_MAX;
            predicted_drives.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    rgbw_pkg::REG_BRIGHTNESS:  gain = cfg_data.value;
                    rgbw_pkg::REG_WHITE_RED:   white_r = cfg_data.value;
                    rgbw_pkg::REG_WHITE_GREEN: white_g = cfg_data.value;
                    rgbw_pkg::REG_WHITE_BLUE:  white_b = cfg_data.value;
                    default: ;
                endcase
            end
            if (pixel_valid && pixel_ready)
                predicted_drives.push_back(rgbw_of(pixel_data));
            if (drive_valid && drive_ready)
            begin
                if (predicted_drives.size() == 0)
                begin
                    $error("drive transaction with no pixel outstanding: %h", drive_data);
                    mismatches++;
                end
                else
                begin
                    want = predicted_drives.pop_front();
                    mismatches += field_bad("white_out", want.white_out, drive_data.white_out);
                    mismatches += field_bad("red_out", want.red_out, drive_data.red_out);
                    mismatches += field_bad("green_out", want.green_out, drive_data.green_out);
                    mismatches += field_bad("blue_out", want.blue_out, drive_data.blue_out);
                end
            end
            pending <= predicted_drives.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the RGB to RGBW converter testbench: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int          PIPE_LATENCY      = 12;
    localparam int          DRIVE_HOLD_AT     = 150;
    localparam int          DRIVE_HOLD_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT    = 4000;
    localparam logic [7:0]  REG_UNMAPPED_LO   = 8'd4;
    localparam logic [7:0]  REG_UNMAPPED_HI   = 8'd255;

    logic        clk = 1'b0;
    logic        rst_n;
    bit          idling;
    int unsigned pixels_sent;
    int unsigned mismatches;
    int unsigned pending;
    int unsigned quiet_cycles;

    rgbw_stream_if #(.payload_t(rgbw_pkg::pixel_t)) pixel_ch ();
    rgbw_stream_if #(.payload_t(rgbw_pkg::drive_t)) drive_ch ();
    rgbw_stream_if #(.payload_t(rgbw_pkg::cfg_t))   cfg_ch ();

    rgb_to_rgbw_pixel_converter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .drive (drive_ch),
        .cfg   (cfg_ch)
    );

    rgbw_checker drive_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_ch.valid),
        .pixel_ready (pixel_ch.ready),
        .pixel_data  (pixel_ch.data),
        .drive_valid (drive_ch.valid),
        .drive_ready (drive_ch.ready),
        .drive_data  (drive_ch.data),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_data    (cfg_ch.data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length for either side: mostly none, some short, a few long
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (!idling || roll < 12)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Channel or register level biased toward the extremes
    function automatic logic [7:0] pick_level();
        logic [7:0] level;
        case ($urandom_range(0, 7))
            0: level = 8'd0;
            1: level = 8'd255;
            2: level = 8'd1;
            default: level = 8'($urandom_range(0, 255));
        endcase
        return level;
    endfunction

    function automatic rgbw_pkg::pixel_t random_pixel();
        rgbw_pkg::pixel_t p;
        p.red_in   = pick_level();
        p.green_in = pick_level();
        p.blue_in  = pick_level();
        // Equal channels exercise the tie in the minimum search
        if ($urandom_range(0, 9) == 0)
        begin
            p.green_in = p.red_in;
            p.blue_in  = p.red_in;
        end
        return p;
    endfunction

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(input rgbw_pkg::pixel_t p);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.data  <= p;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        pixels_sent++;
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rgbw_pkg::pixel_t p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        send_pixel(p);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        rgbw_pkg::cfg_t w;
        w.index = index;
        w.value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // Stop offering pixels and wait until every drive has come back
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Load all four registers once the pipeline is empty
    task automatic program_regs(input logic [7:0] b, input logic [7:0] kr,
                                input logic [7:0] kg, input logic [7:0] kb,
                                input bit with_unmapped);
        drain();
        write_reg(rgbw_pkg::REG_BRIGHTNESS, b);
        write_reg(rgbw_pkg::REG_WHITE_RED, kr);
        write_reg(rgbw_pkg::REG_WHITE_GREEN, kg);
        write_reg(rgbw_pkg::REG_WHITE_BLUE, kb);
        // Writes to unmapped indexes must be dropped
        if (with_unmapped)
        begin
            write_reg(REG_UNMAPPED_LO, 8'd0);
            write_reg(REG_UNMAPPED_HI, 8'd1);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Drive side: random ready gaps, plus one long hold-off to fill the pipeline
    initial
    begin
        int  gap;
        bit  hold_done;
        hold_done = 1'b0;
        drive_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (!hold_done && pixels_sent >= DRIVE_HOLD_AT)
            begin
                drive_ch.ready <= 1'b0;
                repeat (DRIVE_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                begin
                    drive_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                drive_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Abort when no channel moves a transaction for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((pixel_ch.valid && pixel_ch.ready) || (drive_ch.valid && drive_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rgb_to_rgbw_pixel_converter verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        idling = 1'b1;
        pixels_sent = 0;
        rst_n <= 1'b0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.data  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: full brightness, white LED at full content
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd200, 8'd100, 8'd50);
        send_rgb(8'd1, 8'd254, 8'd170);
        send_random(50);

        // Zero brightness with minimal contents: everything collapses to zero
        idling = 1'b0;
        program_regs(8'd0, 8'd1, 8'd1, 8'd1, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd127);
        send_random(30);

        // Full brightness, lopsided white LED
        idling = 1'b1;
        program_regs(8'd255, 8'd255, 8'd1, 8'd128, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd2, 8'd255);
        send_rgb(8'd10, 8'd255, 8'd5);
        send_rgb(8'd0, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd1, 8'd128);
        send_random(50);

        // Minimal brightness
        idling = 1'b0;
        program_regs(8'd1, 8'd1, 8'd255, 8'd1, 1'b0);
        send_random(30);

        // Zero contents act as one; unmapped writes are dropped
        idling = 1'b1;
        program_regs(8'd200, 8'd0, 8'd0, 8'd0, 1'b1);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd9, 8'd3, 8'd6);
        send_rgb(8'd0, 8'd200, 8'd100);
        send_rgb(8'd77, 8'd77, 8'd77);
        send_random(40);

        // Random register settings
        repeat (5)
        begin
            idling = ($urandom_range(0, 3) != 0);
            program_regs(pick_level(), pick_level(), pick_level(), pick_level(), 1'b0);
            send_random(50);
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("rgb_to_rgbw_pixel_converter verification clean");
        else
            $display("rgb_to_rgbw_pixel_converter verification failed");
        $finish;
    end

endmodule
